// File: sv/tts_pkg.sv
// Shared types and constants of the task table scheduler.
package tts_pkg;

    localparam int SLOT_COUNT = 64;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

    localparam logic [2:0] ST_UNUSED   = 3'd0;
    localparam logic [2:0] ST_SPARE    = 3'd1;
    localparam logic [2:0] ST_RUNNABLE = 3'd2;
    localparam logic [2:0] ST_IDLE     = 3'd3;
    localparam logic [2:0] ST_WAITING  = 3'd4;

    localparam logic [31:0] TICK_MAX = 32'hFFFF_FFFF;

    typedef enum logic [3:0] {
        CMD_CREATE    = 4'd0,
        CMD_SLEEP     = 4'd1,
        CMD_WAIT_IRQ  = 4'd2,
        CMD_WAKE_SLOT = 4'd3,
        CMD_WAKE_IRQ  = 4'd4,
        CMD_EXIT      = 4'd5,
        CMD_YIELD     = 4'd6,
        CMD_DISPATCH  = 4'd7,
        CMD_TICK      = 4'd8,
        CMD_QUERY     = 4'd9
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_FULL    = 2'd1,
        STS_NONE    = 2'd2,
        STS_IGNORED = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_WAIT,
        S_RESP
    } t_state;

    typedef struct packed {
        logic latch;
        logic exec;
        logic scan;
        logic rd_done;
        logic resp;
    } t_ctl;

    typedef struct packed {
        logic go_scan;
        logic go_wait;
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

// File: sv/tts_ram.sv
// Generic simple dual-port RAM with a registered read port.
module tts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: sv/tts_datapath.sv
// Datapath of the task table scheduler: slot tables, scan counters and result word.
module tts_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tts_pkg::t_ctl  i_ctl,
    output tts_pkg::t_sts  o_sts,
    input  logic [3:0]     i_command,
    input  logic [5:0]     i_slot,
    input  logic [7:0]     i_irq_number,
    input  logic           i_stall,
    output logic           o_valid,
    output logic [1:0]     o_status,
    output logic [5:0]     o_result_slot,
    output logic           o_needs_new_stack,
    output logic [6:0]     o_woken_count,
    output logic [2:0]     o_slot_state,
    output logic [31:0]    o_slot_ticks,
    output logic           o_scheduler_running,
    output logic [5:0]     o_running_slot
);
    import tts_pkg::*;

    t_cmd              r_cmd;
    logic [5:0]        r_slot;
    logic [7:0]        r_irq;
    logic              r_sched;
    logic [SLOT_W-1:0] r_cur;
    logic [SLOT_W-1:0] r_scan_pos;
    logic [SLOT_COUNT-1:0] r_st_vld;
    logic [SLOT_COUNT-1:0] r_tk_vld;
    logic [SLOT_W-1:0] r_addr;
    logic [CNT_W-1:0]  r_issued;
    logic              r_chk_on;
    logic              r_chk_last;
    logic [SLOT_W-1:0] r_chk_idx;
    logic              r_chk_sv;
    logic              r_chk_tv;

    t_status           r_res_status;
    logic [5:0]        r_res_slot;
    logic              r_res_ns;
    logic [CNT_W-1:0]  r_res_woken;
    logic [2:0]        r_res_qstate;
    logic [31:0]       r_res_qticks;

    logic              r_o_valid;
    logic [1:0]        r_o_status;
    logic [5:0]        r_o_slot;
    logic              r_o_ns;
    logic [6:0]        r_o_woken;
    logic [2:0]        r_o_qstate;
    logic [31:0]       r_o_qticks;
    logic              r_o_sched;
    logic [5:0]        r_o_run;

    logic [SLOT_W-1:0] w_slot_idx;
    logic              w_slot_ok;
    logic [SLOT_W-1:0] w_raddr;
    logic              w_issue;
    logic [2:0]        w_st_q;
    logic [7:0]        w_irq_q;
    logic [31:0]       w_tk_raw;
    logic [2:0]        w_st;
    logic [31:0]       w_tk;
    logic              w_is_leave;
    logic [2:0]        w_leave_st;
    logic              w_hit;
    logic              w_stop;
    logic              w_st_we;
    logic [SLOT_W-1:0] w_st_waddr;
    logic [2:0]        w_st_wdata;
    logic              w_irq_we;
    logic              w_tk_we;
    logic [SLOT_W-1:0] w_next_addr;

    assign w_slot_idx  = SLOT_W'(r_slot);
    assign w_slot_ok   = 32'(r_slot) < SLOT_COUNT;
    assign w_issue     = i_ctl.scan && (r_issued < CNT_W'(SLOT_COUNT));
    assign w_next_addr = (r_addr == SLOT_W'(SLOT_COUNT - 1)) ? '0 : r_addr + 1'b1;

    always_comb begin
        if (i_ctl.exec && r_cmd == CMD_QUERY) begin
            w_raddr = w_slot_idx;
        end else if (i_ctl.exec) begin
            w_raddr = r_cur;
        end else begin
            w_raddr = r_addr;
        end
    end

    assign w_st = r_chk_sv ? w_st_q : ST_UNUSED;
    assign w_tk = r_chk_tv ? w_tk_raw : '0;

    always_comb begin
        w_is_leave = 1'b1;
        w_leave_st = ST_IDLE;
        case (r_cmd)
            CMD_SLEEP:    w_leave_st = ST_IDLE;
            CMD_WAIT_IRQ: w_leave_st = ST_WAITING;
            CMD_EXIT:     w_leave_st = ST_SPARE;
            CMD_YIELD:    w_leave_st = ST_RUNNABLE;
            default:      w_is_leave = 1'b0;
        endcase
    end

    always_comb begin
        w_hit = 1'b0;
        case (r_cmd)
            CMD_CREATE:   w_hit = (w_st == ST_UNUSED) || (w_st == ST_SPARE);
            CMD_DISPATCH: w_hit = (w_st == ST_RUNNABLE);
            CMD_WAKE_IRQ: w_hit = (w_st == ST_WAITING) && (w_irq_q == r_irq);
            default:      w_hit = 1'b0;
        endcase
        w_hit = w_hit && r_chk_on && i_ctl.scan;
    end

    assign w_stop = w_hit && (r_cmd != CMD_WAKE_IRQ);

    always_comb begin
        w_st_we    = 1'b0;
        w_st_waddr = r_chk_idx;
        w_st_wdata = ST_RUNNABLE;
        w_irq_we   = 1'b0;
        if (i_ctl.exec && w_is_leave && !r_sched) begin
            w_st_we    = 1'b1;
            w_st_waddr = r_cur;
            w_st_wdata = w_leave_st;
            w_irq_we   = (r_cmd == CMD_WAIT_IRQ);
        end else if (i_ctl.exec && r_cmd == CMD_WAKE_SLOT && w_slot_ok) begin
            w_st_we    = 1'b1;
            w_st_waddr = w_slot_idx;
        end else if (w_hit && r_cmd != CMD_DISPATCH) begin
            w_st_we    = 1'b1;
        end
    end

    assign w_tk_we = i_ctl.rd_done && r_cmd == CMD_TICK && w_tk != TICK_MAX;

    tts_ram #(.WIDTH(3), .DEPTH(SLOT_COUNT)) u_st_ram (
        .i_clk   (i_clk),
        .i_we    (w_st_we),
        .i_waddr (w_st_waddr),
        .i_wdata (w_st_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_st_q)
    );

    tts_ram #(.WIDTH(8), .DEPTH(SLOT_COUNT)) u_irq_ram (
        .i_clk   (i_clk),
        .i_we    (w_irq_we),
        .i_waddr (r_cur),
        .i_wdata (r_irq),
        .i_raddr (w_raddr),
        .o_rdata (w_irq_q)
    );

    tts_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT)) u_tk_ram (
        .i_clk   (i_clk),
        .i_we    (w_tk_we),
        .i_waddr (r_chk_idx),
        .i_wdata (w_tk + 32'd1),
        .i_raddr (w_raddr),
        .o_rdata (w_tk_raw)
    );

    always_ff @(posedge i_clk) begin
        r_chk_idx  <= w_raddr;
        r_chk_sv   <= r_st_vld[w_raddr];
        r_chk_tv   <= r_tk_vld[w_raddr];
        r_chk_last <= (r_issued == CNT_W'(SLOT_COUNT - 1));
        if (i_ctl.latch) begin
            r_cmd        <= t_cmd'(i_command);
            r_slot       <= i_slot;
            r_irq        <= i_irq_number;
            r_res_status <= STS_OK;
            r_res_slot   <= '0;
            r_res_ns     <= 1'b0;
            r_res_woken  <= '0;
            r_res_qstate <= '0;
            r_res_qticks <= '0;
        end
        if (i_ctl.exec) begin
            r_issued <= '0;
            r_addr   <= (r_cmd == CMD_DISPATCH) ? r_scan_pos : '0;
            case (r_cmd)
                CMD_CREATE: r_res_status <= STS_FULL;
                CMD_DISPATCH: r_res_status <= r_sched ? STS_NONE : STS_IGNORED;
                CMD_SLEEP, CMD_WAIT_IRQ, CMD_EXIT, CMD_YIELD, CMD_TICK: begin
                    if (r_sched) begin
                        r_res_status <= STS_IGNORED;
                    end
                end
                CMD_QUERY: r_res_slot <= r_slot;
                default: ;
            endcase
        end
        if (w_issue) begin
            r_addr   <= w_next_addr;
            r_issued <= r_issued + 1'b1;
        end
        if (w_hit) begin
            case (r_cmd)
                CMD_CREATE: begin
                    r_res_status <= STS_OK;
                    r_res_slot   <= 6'(r_chk_idx);
                    r_res_ns     <= (w_st == ST_UNUSED);
                end
                CMD_DISPATCH: begin
                    r_res_status <= STS_OK;
                    r_res_slot   <= 6'(r_chk_idx);
                end
                default: r_res_woken <= r_res_woken + 1'b1;
            endcase
        end
        if (i_ctl.rd_done && r_cmd == CMD_QUERY && w_slot_ok) begin
            r_res_qstate <= w_st;
            r_res_qticks <= w_tk;
        end
        if (i_ctl.resp && o_sts.out_free) begin
            r_o_status <= r_res_status;
            r_o_slot   <= r_res_slot;
            r_o_ns     <= r_res_ns;
            r_o_woken  <= 7'(r_res_woken);
            r_o_qstate <= r_res_qstate;
            r_o_qticks <= r_res_qticks;
            r_o_sched  <= r_sched;
            r_o_run    <= r_sched ? 6'd0 : 6'(r_cur);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sched    <= 1'b1;
            r_cur      <= '0;
            r_scan_pos <= '0;
            r_st_vld   <= '0;
            r_tk_vld   <= '0;
            r_chk_on   <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_chk_on <= w_issue;
            if (w_st_we) begin
                r_st_vld[w_st_waddr] <= 1'b1;
            end
            if (w_hit && r_cmd == CMD_CREATE) begin
                r_tk_vld[r_chk_idx] <= 1'b0;
            end
            if (w_tk_we) begin
                r_tk_vld[r_chk_idx] <= 1'b1;
            end
            if (i_ctl.exec && w_is_leave) begin
                r_sched <= 1'b1;
            end
            if (w_hit && r_cmd == CMD_DISPATCH) begin
                r_cur      <= r_chk_idx;
                r_sched    <= 1'b0;
                r_scan_pos <= (r_chk_idx == SLOT_W'(SLOT_COUNT - 1)) ? '0 : r_chk_idx + 1'b1;
            end
            if (i_ctl.resp && o_sts.out_free) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_sts.go_scan   = (r_cmd == CMD_CREATE) || (r_cmd == CMD_WAKE_IRQ)
                             || (r_cmd == CMD_DISPATCH && r_sched);
    assign o_sts.go_wait   = (r_cmd == CMD_QUERY) || (r_cmd == CMD_TICK && !r_sched);
    assign o_sts.scan_done = r_chk_on && (w_stop || r_chk_last);
    assign o_sts.out_free  = !r_o_valid || !i_stall;

    assign o_valid             = r_o_valid;
    assign o_status            = r_o_status;
    assign o_result_slot       = r_o_slot;
    assign o_needs_new_stack   = r_o_ns;
    assign o_woken_count       = r_o_woken;
    assign o_slot_state        = r_o_qstate;
    assign o_slot_ticks        = r_o_qticks;
    assign o_scheduler_running = r_o_sched;
    assign o_running_slot      = r_o_run;
endmodule

// File: sv/tts_controller.sv
// Command sequencer of the task table scheduler.
module tts_controller (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_busy,
    input  tts_pkg::t_sts i_sts,
    output tts_pkg::t_ctl o_ctl
);
    import tts_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_EXEC;
            S_EXEC: begin
                if (i_sts.go_scan) begin
                    n_state = S_SCAN;
                end else if (i_sts.go_wait) begin
                    n_state = S_WAIT;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_SCAN: if (i_sts.scan_done) n_state = S_RESP;
            S_WAIT: n_state = S_RESP;
            S_RESP: if (i_sts.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_busy      = 1'b0;
                o_ctl.latch = i_valid;
            end
            S_EXEC: o_ctl.exec    = 1'b1;
            S_SCAN: o_ctl.scan    = 1'b1;
            S_WAIT: o_ctl.rd_done = 1'b1;
            S_RESP: o_ctl.resp    = 1'b1;
            default: o_busy = 1'b1;
        endcase
    end
endmodule

// File: sv/task_table_scheduler.sv
// Top level of the task table scheduler.
// One word at a time: create, wake-by-interrupt and dispatch (while the scheduler runs) scan
// the slot table one slot a cycle through the state memory read port.
// Other commands skip the scan; query, and tick while a task runs, pass a read wait state.
// Synchronous active-low reset: all slots unused, scheduler running, scan at slot 0.
// The result register lets the next word be accepted while a result waits.
module task_table_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_command,
    input  logic [5:0]  i_slot,
    input  logic [7:0]  i_irq_number,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [5:0]  o_result_slot,
    output logic        o_needs_new_stack,
    output logic [6:0]  o_woken_count,
    output logic [2:0]  o_slot_state,
    output logic [31:0] o_slot_ticks,
    output logic        o_scheduler_running,
    output logic [5:0]  o_running_slot
);
    import tts_pkg::*;

    t_ctl w_ctl;
    t_sts w_sts;
    logic w_busy;

    assign o_stall = w_busy;

    tts_controller u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_busy  (w_busy),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl)
    );

    tts_datapath u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_ctl               (w_ctl),
        .o_sts               (w_sts),
        .i_command           (i_command),
        .i_slot              (i_slot),
        .i_irq_number        (i_irq_number),
        .i_stall             (i_stall),
        .o_valid             (o_valid),
        .o_status            (o_status),
        .o_result_slot       (o_result_slot),
        .o_needs_new_stack   (o_needs_new_stack),
        .o_woken_count       (o_woken_count),
        .o_slot_state        (o_slot_state),
        .o_slot_ticks        (o_slot_ticks),
        .o_scheduler_running (o_scheduler_running),
        .o_running_slot      (o_running_slot)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("Accepted word did not make the block busy.");

    a_none_sched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == STS_NONE |-> o_scheduler_running)
        else $error("Failed dispatch left a task running.");

    a_stack_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_needs_new_stack |-> o_status == STS_OK)
        else $error("New stack flagged on a failed word.");
endmodule
